// ----- sv/dpcr_pkg.sv -----
// ----------------------------------------------------------------------------
// dpcr_pkg
// Types and constants shared by the disk pair collision resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package dpcr_pkg;

  localparam int FieldW  = 24;
  localparam int RadiusW = 21;
  localparam int DiffW   = FieldW + 1;
  localparam int RootW   = RadiusW + 1;
  localparam int RadW    = 2 * RootW;
  localparam int RemW    = RootW + 2;
  localparam int QuotW   = 21;
  localparam int NormW   = QuotW + 1;
  localparam int SqSteps = RootW;
  localparam int DvSteps = QuotW;
  localparam int SatW    = 32;

  localparam logic [RadiusW-1:0] RadiusReset = 21'd5243;

  typedef struct packed {
    logic signed [FieldW-1:0] first_pos_x;
    logic signed [FieldW-1:0] first_pos_y;
    logic signed [FieldW-1:0] first_vel_x;
    logic signed [FieldW-1:0] first_vel_y;
    logic signed [FieldW-1:0] second_pos_x;
    logic signed [FieldW-1:0] second_pos_y;
    logic signed [FieldW-1:0] second_vel_x;
    logic signed [FieldW-1:0] second_vel_y;
  } dpcr_in_t;

  typedef struct packed {
    logic                     collided;
    logic signed [FieldW-1:0] new_first_pos_x;
    logic signed [FieldW-1:0] new_first_pos_y;
    logic signed [FieldW-1:0] new_first_vel_x;
    logic signed [FieldW-1:0] new_first_vel_y;
    logic signed [FieldW-1:0] new_second_pos_x;
    logic signed [FieldW-1:0] new_second_pos_y;
    logic signed [FieldW-1:0] new_second_vel_x;
    logic signed [FieldW-1:0] new_second_vel_y;
  } dpcr_out_t;

  typedef struct packed {
    dpcr_in_t                item;
    logic                    hit;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dvx;
    logic signed [DiffW-1:0] dvy;
    logic [RootW-1:0]        r;
  } dpcr_ctx_t;

  function automatic logic signed [FieldW-1:0] sat_field(input logic signed [SatW-1:0] v);
    logic signed [SatW-1:0] hi;
    logic signed [SatW-1:0] lo;
    hi = SatW'(signed'({1'b0, {(FieldW-1){1'b1}}}));
    lo = -hi - SatW'(1);
    if (v > hi) begin
      return {1'b0, {(FieldW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(FieldW-1){1'b0}}};
    end
    return v[FieldW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/disk_pair_collision_resolve.sv -----
// ----------------------------------------------------------------------------
// disk_pair_collision_resolve
// Resolves an elastic collision between two equal disks in Q3.20.
//
// Each request on the input channel carries the positions and velocities of
// two disks. The result request carries the collision flag and the updated
// values, saturated to the field range. Both channels use valid and stall.
// The radius is written through a separate valid/ready port that is always
// ready; it resets to 5243.
// The pipeline has 51 register stages: three for the distance test, 22 for
// the bit-per-stage square root, 21 for the two bit-per-stage divisions that
// form the unit normal, and five for the multiplies and the final update.
// A request can enter in every cycle, so throughput is one per cycle while the
// receiver does not stall. When the receiver stalls a waiting result, the whole
// pipeline holds and the input is stalled; nothing is lost or repeated.
// Reset clears all valid bits and restores the radius.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_pair_collision_resolve (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire dpcr_pkg::dpcr_in_t      in_data_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output dpcr_pkg::dpcr_out_t          out_data_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [dpcr_pkg::RadiusW-1:0]  cfg_data_i
);
  import dpcr_pkg::*;

  logic en;
  logic [RadiusW-1:0] radius_q;

  logic      s1_v_q, s2_v_q, s3_v_q;
  dpcr_ctx_t s1_q, s2_q, s3_q;
  logic [2*FieldW-1:0] s2_sqx_q, s2_sqy_q;
  logic [RadW-1:0]     s2_rr_q;
  logic [RadW-1:0]     s3_rad_q;

  logic             sq_v_q    [SqSteps];
  dpcr_ctx_t        sq_ctx_q  [SqSteps];
  logic [RadW-1:0]  sq_rad_q  [SqSteps];
  logic [RootW-1:0] sq_root_q [SqSteps];
  logic [RemW-1:0]  sq_rem_q  [SqSteps];

  logic             dv_v_q   [DvSteps];
  dpcr_ctx_t        dv_ctx_q [DvSteps];
  logic [RootW-1:0] dv_len_q [DvSteps];
  logic [RootW:0]   dv_rx_q  [DvSteps];
  logic [RootW:0]   dv_ry_q  [DvSteps];
  logic [QuotW-1:0] dv_qx_q  [DvSteps];
  logic [QuotW-1:0] dv_qy_q  [DvSteps];

  logic m1_v_q, m2_v_q, m3_v_q, m4_v_q, out_v_q;
  dpcr_ctx_t m1_ctx_q, m2_ctx_q, m3_ctx_q, m4_ctx_q;
  logic signed [NormW-1:0] m1_nx_q, m1_ny_q, m2_nx_q, m2_ny_q, m3_nx_q, m3_ny_q;
  logic signed [RootW:0]   m1_depth_q;
  logic signed [44:0]      m2_pmx_q, m2_pmy_q;
  logic signed [46:0]      m2_pvx_q, m2_pvy_q;
  logic signed [FieldW-1:0] m3_mx_q, m3_my_q, m4_mx_q, m4_my_q;
  logic signed [27:0]      m3_vn_q;
  logic signed [49:0]      m4_pux_q, m4_puy_q;
  dpcr_out_t out_q;

  assign en          = !(out_v_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      m1_v_q  <= 1'b0;
      m2_v_q  <= 1'b0;
      m3_v_q  <= 1'b0;
      m4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      m1_v_q  <= dv_v_q[DvSteps-1];
      m2_v_q  <= m1_v_q;
      m3_v_q  <= m2_v_q;
      m4_v_q  <= m3_v_q;
      out_v_q <= m4_v_q;
    end
  end

  // Differences, squares and the distance test.
  logic [2*FieldW:0] d2;
  assign d2 = {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};

  dpcr_ctx_t s3_d;
  always_comb begin
    s3_d     = s2_q;
    s3_d.hit = (d2 != '0) && (d2 < {{(2*FieldW+1-RadW){1'b0}}, s2_rr_q});
  end

  logic signed [2*DiffW-1:0] sqx_full, sqy_full;
  logic [RadW-1:0] rr_full;
  assign sqx_full = s1_q.dx * s1_q.dx;
  assign sqy_full = s1_q.dy * s1_q.dy;
  assign rr_full  = s1_q.r * s1_q.r;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.item <= in_data_i;
      s1_q.hit  <= 1'b0;
      s1_q.dx   <= DiffW'(in_data_i.first_pos_x) - DiffW'(in_data_i.second_pos_x);
      s1_q.dy   <= DiffW'(in_data_i.first_pos_y) - DiffW'(in_data_i.second_pos_y);
      s1_q.dvx  <= DiffW'(in_data_i.second_vel_x) - DiffW'(in_data_i.first_vel_x);
      s1_q.dvy  <= DiffW'(in_data_i.second_vel_y) - DiffW'(in_data_i.first_vel_y);
      s1_q.r    <= {radius_q, 1'b0};
      s2_q      <= s1_q;
      s2_sqx_q  <= sqx_full[2*FieldW-1:0];
      s2_sqy_q  <= sqy_full[2*FieldW-1:0];
      s2_rr_q   <= rr_full;
      s3_q      <= s3_d;
      s3_rad_q  <= d2[RadW-1:0];
    end
  end

  // Square root, one result bit per stage.
  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    logic             v_in;
    dpcr_ctx_t        ctx_in;
    logic [RadW-1:0]  rad_in;
    logic [RootW-1:0] root_in;
    logic [RemW-1:0]  rem_in, rem_sh, trial;
    logic             ge;
    if (k == 0) begin : g_first
      assign v_in    = s3_v_q;
      assign ctx_in  = s3_q;
      assign rad_in  = s3_rad_q;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign v_in    = sq_v_q[k-1];
      assign ctx_in  = sq_ctx_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
    end
    assign rem_sh = {rem_in[RemW-3:0], rad_in[RadW-1-2*k -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (en) begin
        sq_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_ctx_q[k]  <= ctx_in;
        sq_rad_q[k]  <= rad_in;
        sq_root_q[k] <= {root_in[RootW-2:0], ge};
        sq_rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
      end
    end
  end

  // Unit normal: |d| * 2^20 / L, one quotient bit per stage for x and y.
  for (genvar j = 0; j < DvSteps; j++) begin : g_div
    logic             v_in;
    dpcr_ctx_t        ctx_in;
    logic [RootW-1:0] len_in;
    logic [RootW:0]   rx_in, ry_in, len_ext;
    logic [QuotW-1:0] qx_in, qy_in;
    logic             gex, gey;
    if (j == 0) begin : g_first
      logic [DiffW-1:0] adx, ady;
      assign v_in   = sq_v_q[SqSteps-1];
      assign ctx_in = sq_ctx_q[SqSteps-1];
      assign len_in = sq_root_q[SqSteps-1];
      assign adx    = ctx_in.dx[DiffW-1] ? DiffW'(-ctx_in.dx) : DiffW'(ctx_in.dx);
      assign ady    = ctx_in.dy[DiffW-1] ? DiffW'(-ctx_in.dy) : DiffW'(ctx_in.dy);
      assign rx_in  = adx[RootW:0];
      assign ry_in  = ady[RootW:0];
      assign qx_in  = '0;
      assign qy_in  = '0;
    end else begin : g_next
      assign v_in   = dv_v_q[j-1];
      assign ctx_in = dv_ctx_q[j-1];
      assign len_in = dv_len_q[j-1];
      assign rx_in  = {dv_rx_q[j-1][RootW-1:0], 1'b0};
      assign ry_in  = {dv_ry_q[j-1][RootW-1:0], 1'b0};
      assign qx_in  = dv_qx_q[j-1];
      assign qy_in  = dv_qy_q[j-1];
    end
    assign len_ext = {1'b0, len_in};
    assign gex     = rx_in >= len_ext;
    assign gey     = ry_in >= len_ext;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else if (en) begin
        dv_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_ctx_q[j] <= ctx_in;
        dv_len_q[j] <= len_in;
        dv_rx_q[j]  <= gex ? rx_in - len_ext : rx_in;
        dv_ry_q[j]  <= gey ? ry_in - len_ext : ry_in;
        dv_qx_q[j]  <= {qx_in[QuotW-2:0], gex};
        dv_qy_q[j]  <= {qy_in[QuotW-2:0], gey};
      end
    end
  end

  // Signed normal, push depth, products and the final update.
  dpcr_ctx_t dv_last;
  logic [NormW-1:0] qx_ext, qy_ext;
  assign dv_last = dv_ctx_q[DvSteps-1];
  assign qx_ext  = {1'b0, dv_qx_q[DvSteps-1]};
  assign qy_ext  = {1'b0, dv_qy_q[DvSteps-1]};

  logic signed [47:0] vsum, vsum_adj;
  logic signed [44:0] pmx_adj, pmy_adj;
  logic signed [49:0] pux_adj, puy_adj;
  logic signed [29:0] ux, uy;
  assign vsum     = 48'(m2_pvx_q) + 48'(m2_pvy_q);
  assign vsum_adj = vsum + {28'd0, {20{vsum[47]}}};
  assign pmx_adj  = m2_pmx_q + {24'd0, {21{m2_pmx_q[44]}}};
  assign pmy_adj  = m2_pmy_q + {24'd0, {21{m2_pmy_q[44]}}};
  assign pux_adj  = m4_pux_q + {30'd0, {20{m4_pux_q[49]}}};
  assign puy_adj  = m4_puy_q + {30'd0, {20{m4_puy_q[49]}}};
  assign ux       = pux_adj[49:20];
  assign uy       = puy_adj[49:20];

  dpcr_out_t out_d;
  dpcr_in_t  it;
  assign it = m4_ctx_q.item;

  always_comb begin
    out_d.collided = m4_ctx_q.hit;
    if (m4_ctx_q.hit) begin
      out_d.new_first_pos_x  = sat_field(SatW'(it.first_pos_x) + SatW'(m4_mx_q));
      out_d.new_first_pos_y  = sat_field(SatW'(it.first_pos_y) + SatW'(m4_my_q));
      out_d.new_second_pos_x = sat_field(SatW'(it.second_pos_x) - SatW'(m4_mx_q));
      out_d.new_second_pos_y = sat_field(SatW'(it.second_pos_y) - SatW'(m4_my_q));
      out_d.new_first_vel_x  = sat_field(SatW'(it.first_vel_x) + SatW'(ux));
      out_d.new_first_vel_y  = sat_field(SatW'(it.first_vel_y) + SatW'(uy));
      out_d.new_second_vel_x = sat_field(SatW'(it.second_vel_x) - SatW'(ux));
      out_d.new_second_vel_y = sat_field(SatW'(it.second_vel_y) - SatW'(uy));
    end else begin
      out_d.new_first_pos_x  = it.first_pos_x;
      out_d.new_first_pos_y  = it.first_pos_y;
      out_d.new_second_pos_x = it.second_pos_x;
      out_d.new_second_pos_y = it.second_pos_y;
      out_d.new_first_vel_x  = it.first_vel_x;
      out_d.new_first_vel_y  = it.first_vel_y;
      out_d.new_second_vel_x = it.second_vel_x;
      out_d.new_second_vel_y = it.second_vel_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_ctx_q   <= dv_last;
      m1_nx_q    <= dv_last.dx[DiffW-1] ? signed'(NormW'(0) - qx_ext) : signed'(qx_ext);
      m1_ny_q    <= dv_last.dy[DiffW-1] ? signed'(NormW'(0) - qy_ext) : signed'(qy_ext);
      m1_depth_q <= signed'({1'b0, dv_last.r} - {1'b0, dv_len_q[DvSteps-1]});
      m2_ctx_q   <= m1_ctx_q;
      m2_nx_q    <= m1_nx_q;
      m2_ny_q    <= m1_ny_q;
      m2_pmx_q   <= m1_depth_q * m1_nx_q;
      m2_pmy_q   <= m1_depth_q * m1_ny_q;
      m2_pvx_q   <= m1_ctx_q.dvx * m1_nx_q;
      m2_pvy_q   <= m1_ctx_q.dvy * m1_ny_q;
      m3_ctx_q   <= m2_ctx_q;
      m3_nx_q    <= m2_nx_q;
      m3_ny_q    <= m2_ny_q;
      m3_mx_q    <= pmx_adj[44:21];
      m3_my_q    <= pmy_adj[44:21];
      m3_vn_q    <= vsum_adj[47:20];
      m4_ctx_q   <= m3_ctx_q;
      m4_mx_q    <= m3_mx_q;
      m4_my_q    <= m3_my_q;
      m4_pux_q   <= m3_vn_q * m3_nx_q;
      m4_puy_q   <= m3_vn_q * m3_ny_q;
      out_q      <= out_d;
    end
  end

  // The root of an overlapping pair is always below the contact distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[0] && dv_ctx_q[0].hit |-> dv_len_q[0] < dv_ctx_q[0].r)
    else $error("root not below contact distance");

  // A normal component never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[DvSteps-1] && dv_last.hit |->
      dv_qx_q[DvSteps-1] <= QuotW'(1 << 20) && dv_qy_q[DvSteps-1] <= QuotW'(1 << 20))
    else $error("normal component out of range");

  // An overlapping pair always has a positive push depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m1_v_q && m1_ctx_q.hit |-> m1_depth_q > 0)
    else $error("push depth not positive");

  // A stalled result freezes the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> $stable(sq_v_q[SqSteps-1]) && $stable(m4_v_q))
    else $error("pipeline moved under stall");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Disk pair collision resolver testbench
// Drives random and directed disk pairs through the resolver, predicts each
// result with an integer model of the collision response, and compares every
// result in full, with random gaps, stalls and radius changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import dpcr_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  dpcr_in_t in_data;
  logic out_valid;
  logic out_stall;
  dpcr_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [RadiusW-1:0] cfg_data;

  disk_pair_collision_resolve u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  localparam int Latency = 51;
  localparam int CycleLimit = 400000;

  dpcr_in_t pending_pairs[$];
  dpcr_out_t expected_results[$];
  logic [RadiusW-1:0] radius;
  int mismatches;
  int cycles;
  int burst_left;
  int gap_left;
  int hold_off;
  bit hold_request;
  bit cfg_request;
  logic [RadiusW-1:0] cfg_value;
  bit cfg_done;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [FieldW-1:0] clamp24(input longint v);
    if (v > 8388607) return 24'sh7fffff;
    if (v < -8388608) return 24'sh800000;
    return v[FieldW-1:0];
  endfunction

  function automatic dpcr_out_t resolve_pair(input dpcr_in_t p, input logic [RadiusW-1:0] rad);
    dpcr_out_t o;
    longint p1x, p1y, v1x, v1y, p2x, p2y, v2x, v2y;
    longint dx, dy, len, depth, nx, ny, mx, my, vn, ux, uy, rr;
    longint unsigned d2;
    bit hit;
    p1x = p.first_pos_x;  p1y = p.first_pos_y;
    v1x = p.first_vel_x;  v1y = p.first_vel_y;
    p2x = p.second_pos_x; p2y = p.second_pos_y;
    v2x = p.second_vel_x; v2y = p.second_vel_y;
    dx = p1x - p2x;
    dy = p1y - p2y;
    d2 = dx * dx + dy * dy;
    rr = 2 * longint'(rad);
    hit = (d2 != 0) && (d2 < longint'(rr * rr));
    if (hit) begin
      len = int_sqrt(d2);
      depth = rr - len;
      nx = (dx * 1048576) / len;
      ny = (dy * 1048576) / len;
      mx = (depth * nx) / 2097152;
      my = (depth * ny) / 2097152;
      vn = ((v2x - v1x) * nx + (v2y - v1y) * ny) / 1048576;
      ux = (vn * nx) / 1048576;
      uy = (vn * ny) / 1048576;
      p1x += mx; p1y += my; p2x -= mx; p2y -= my;
      v1x += ux; v1y += uy; v2x -= ux; v2y -= uy;
    end
    o.collided = hit;
    o.new_first_pos_x = clamp24(p1x);
    o.new_first_pos_y = clamp24(p1y);
    o.new_first_vel_x = clamp24(v1x);
    o.new_first_vel_y = clamp24(v1y);
    o.new_second_pos_x = clamp24(p2x);
    o.new_second_pos_y = clamp24(p2y);
    o.new_second_vel_x = clamp24(v2x);
    o.new_second_vel_y = clamp24(v2y);
    return o;
  endfunction

  function automatic void add_pair(input dpcr_in_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  function automatic logic signed [FieldW-1:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return FieldW'(int'($urandom_range(0, 15)) - 8);
      default: return FieldW'($urandom);
    endcase
  endfunction

  // Random pair, mostly placed so the disks overlap for the current radius.
  function automatic dpcr_in_t rand_pair(input logic [RadiusW-1:0] rad);
    dpcr_in_t p;
    int span;
    p.first_pos_x = rand_field();
    p.first_pos_y = rand_field();
    p.first_vel_x = rand_field();
    p.first_vel_y = rand_field();
    p.second_vel_x = rand_field();
    p.second_vel_y = rand_field();
    p.second_pos_x = rand_field();
    p.second_pos_y = rand_field();
    if ($urandom_range(0, 9) < 7) begin
      span = (rad == 0) ? 4 : 2 * int'(rad);
      if ($urandom_range(0, 3) == 0) begin
        p.first_vel_x = FieldW'(int'($urandom_range(0, 2000001)) - 1000000);
        p.second_vel_x = FieldW'(int'($urandom_range(0, 2000001)) - 1000000);
      end
      p.second_pos_x = clamp24(longint'(p.first_pos_x)
                               + int'($urandom_range(0, 2 * span)) - span);
      p.second_pos_y = clamp24(longint'(p.first_pos_y)
                               + int'($urandom_range(0, 2 * span)) - span);
    end
    return p;
  endfunction

  function automatic dpcr_in_t make_pair(input int ax, input int ay, input int bx,
                                         input int by, input int vax, input int vbx);
    dpcr_in_t p;
    p.first_pos_x = FieldW'(ax);   p.first_pos_y = FieldW'(ay);
    p.first_vel_x = FieldW'(vax);  p.first_vel_y = FieldW'(-vax);
    p.second_pos_x = FieldW'(bx);  p.second_pos_y = FieldW'(by);
    p.second_vel_x = FieldW'(vbx); p.second_vel_y = FieldW'(vbx);
    return p;
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (!(in_valid && in_stall)) begin
        if (in_valid) begin
          expected_results.insert(expected_results.size(), resolve_pair(in_data, radius));
        end
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_pairs.pop_front();
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_off <= 0;
      mismatches <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("unexpected result %h", out_data);
          mismatches <= mismatches + 1;
        end else begin
          dpcr_out_t exp_r;
          exp_r = expected_results.pop_front();
          if (exp_r !== out_data) begin
            if (mismatches < 10) begin
              $display("mismatch: expected %h actual %h", exp_r, out_data);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (hold_request && hold_off == 0) begin
        hold_off <= 300;
        out_stall <= 1'b1;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= (hold_off != 1);
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 7) != 0);
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cfg_valid <= 1'b0;
      cfg_data <= '0;
      cfg_done <= 1'b0;
    end else begin
      cfg_done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        cfg_valid <= 1'b0;
        cfg_done <= 1'b1;
      end else if (cfg_request && !cfg_valid && !cfg_done) begin
        cfg_valid <= 1'b1;
        cfg_data <= cfg_value;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_pairs.size() > 0 || in_valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic set_radius(input logic [RadiusW-1:0] value);
    wait_drained();
    cfg_value = value;
    cfg_request = 1'b1;
    @(posedge clk);
    while (!cfg_done) @(posedge clk);
    cfg_request = 1'b0;
    radius = value;
  endtask

  logic [RadiusW-1:0] radii[6] = '{21'd5243, 21'd0, 21'd1, 21'h1fffff, 21'd1048576, 21'd300000};

  initial begin
    cycles = 0;
    radius = RadiusReset;
    cfg_request = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    add_pair(make_pair(0, 0, 0, 0, 100, -100));
    add_pair(make_pair(0, 0, 10486, 0, 1000, -1000));
    add_pair(make_pair(0, 0, 5000, 3000, 50000, -7000));
    add_pair(make_pair(8388607, 8388607, 8388600, 8388600,
                       8388607, -8388608));
    add_pair(make_pair(-8388608, -8388608, -8388600, -8388601,
                       -8388608, 8388607));
    add_pair(make_pair(100, 100, 100, 101, 0, 0));
    set_radius(21'd0);
    add_pair(make_pair(0, 0, 1, 0, 10, 20));
    add_pair(make_pair(0, 0, 0, 0, 10, 20));
    set_radius(21'h1fffff);
    add_pair(make_pair(8388607, 8388607, -8388608, -8388608,
                       8388607, -8388608));
    add_pair(make_pair(-8388608, 0, 8388607, 0, -8388608, 8388607));
    add_pair(make_pair(0, 0, 1, 1, 8388607, -8388608));
    set_radius(21'd5);
    add_pair(make_pair(0, 0, 10, 0, 5, -5));
    add_pair(make_pair(0, 0, 9, 0, 5, -5));
    for (int phase = 0; phase < 6; phase++) begin
      set_radius(radii[phase]);
      for (int k = 0; k < 300; k++) add_pair(rand_pair(radius));
      if (phase == 2) begin
        while (pending_pairs.size() > 250) @(posedge clk);
        hold_request = 1'b1;
        @(posedge clk);
        while (hold_off == 0) @(posedge clk);
        hold_request = 1'b0;
      end
    end
    wait_drained();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/dpcr_pkg.sv
sv/disk_pair_collision_resolve.sv
bench/tb.sv
